// ===== hw/rtl/tcce_pkg.sv =====
// tcce_pkg: shared types, codes and constants of the text console cell engine
// used by tcce_ctrl, tcce_dp and text_console_cell_engine
`timescale 1ns / 1ps
package tcce_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_LINES_DEF   = 64;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_SKIP = 2'd3;

    localparam logic [1:0] KIND_DRAW   = 2'd0;
    localparam logic [1:0] KIND_CURSOR = 2'd1;
    localparam logic [1:0] KIND_REDRAW = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int         TAB_STEP = 4;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_VISIBLE = 2'd2;
    localparam logic [1:0] REG_BLINK   = 2'd3;

    localparam logic [7:0]  COLUMNS_RST = 8'd80;
    localparam logic [6:0]  ROWS_RST    = 7'd25;
    localparam logic [15:0] BLINK_RST   = 16'd125;

    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_CLEAR   = 4'd1;
    localparam logic [3:0] CMD_HIDE_RD = 4'd2;
    localparam logic [3:0] CMD_HIDE_EV = 4'd3;
    localparam logic [3:0] CMD_PUT     = 4'd4;
    localparam logic [3:0] CMD_SC_INIT = 4'd5;
    localparam logic [3:0] CMD_SC_RD   = 4'd6;
    localparam logic [3:0] CMD_SC_WR   = 4'd7;
    localparam logic [3:0] CMD_BLANK   = 4'd8;
    localparam logic [3:0] CMD_REDRAW  = 4'd9;
    localparam logic [3:0] CMD_SHOW    = 4'd10;
    localparam logic [3:0] CMD_FINISH  = 4'd11;
    localparam logic [3:0] CMD_TICK    = 4'd12;
    localparam logic [3:0] CMD_CELL_RD = 4'd13;
    localparam logic [3:0] CMD_CELL_EV = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic       last;
        logic       latch;
    } tcce_cmd_t;

    typedef struct packed {
        logic out_free;
        logic clr_last;
        logic geom_zero;
        logic hide_need;
        logic need_scroll;
        logic copy_done;
        logic sx_last;
        logic visible;
        logic blink_on;
        logic tick_fire;
    } tcce_status_t;

    typedef struct packed {
        logic [7:0]  columns;
        logic [6:0]  rows;
        logic        visible;
        logic [15:0] blink_period;
        logic        geom_wr;
        logic        vis_wr;
    } tcce_cfg_t;

endpackage

// ===== hw/rtl/text_console_cell_engine.sv =====
// text_console_cell_engine: top level with the register port
// depends on tcce_pkg, tcce_ctrl and tcce_dp
`timescale 1ns / 1ps
// Character-cell console. After reset the cell store is filled with spaces, one cell
// per cycle, before s_tready first rises; register writes are taken during that pass.
// Items are handled one at a time by a sequencer over the cell memory: a put that
// scrolls copies the rows up and blanks the last row, and adds the redraw and cursor
// beats when shown. Every result beat waits for m_tready on the one-entry result
// register.
module text_console_cell_engine #(
    parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = tcce_pkg::MAX_LINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // character, cell_column, cell_row
    input  logic [1:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // out_column, out_row, out_character
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic        visible_reg;
    logic [15:0] blink_reg;
    logic        geom_wr_reg;
    logic        vis_wr_reg;
    logic        wr_en;

    tcce_pkg::tcce_cmd_t    cmd;
    tcce_pkg::tcce_status_t st;
    tcce_pkg::tcce_cfg_t    cfg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= tcce_pkg::COLUMNS_RST;
            rows_reg    <= tcce_pkg::ROWS_RST;
            visible_reg <= 1'b0;
            blink_reg   <= tcce_pkg::BLINK_RST;
            geom_wr_reg <= 1'b0;
            vis_wr_reg  <= 1'b0;
        end else begin
            geom_wr_reg <= 1'b0;
            vis_wr_reg  <= 1'b0;
            if (wr_en) begin
                unique case (paddr[3:2])
                    tcce_pkg::REG_COLUMNS: begin
                        columns_reg <= pwdata[7:0];
                        geom_wr_reg <= 1'b1;
                    end
                    tcce_pkg::REG_ROWS: begin
                        rows_reg    <= pwdata[6:0];
                        geom_wr_reg <= 1'b1;
                    end
                    tcce_pkg::REG_VISIBLE: begin
                        visible_reg <= pwdata[0];
                        vis_wr_reg  <= pwdata[0];
                    end
                    tcce_pkg::REG_BLINK: blink_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tcce_pkg::REG_COLUMNS: prdata = {24'd0, columns_reg};
            tcce_pkg::REG_ROWS:    prdata = {25'd0, rows_reg};
            tcce_pkg::REG_VISIBLE: prdata = {31'd0, visible_reg};
            tcce_pkg::REG_BLINK:   prdata = {16'd0, blink_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.columns      = columns_reg;
    assign cfg.rows         = rows_reg;
    assign cfg.visible      = visible_reg;
    assign cfg.blink_period = blink_reg;
    assign cfg.geom_wr      = geom_wr_reg;
    assign cfg.vis_wr       = vis_wr_reg;

    tcce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tcce_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a redraw is always followed by the final cursor beat
    a_redraw_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == tcce_pkg::KIND_REDRAW) |-> !m_tlast)
        else $error("redraw beat marked last");

    // a read reply is the only beat of its item
    a_read_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == tcce_pkg::KIND_READ) |-> m_tlast)
        else $error("read reply not marked last");

    // no item is taken while a result beat of the previous one is still to come
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != tcce_pkg::OP_SKIP) |=> !s_tready)
        else $error("input taken while item in progress");

endmodule

// ===== hw/rtl/tcce_ctrl.sv =====
// tcce_ctrl: sequencer of the console, one item at a time
// depends on tcce_pkg; drives tcce_dp through command and status structs
`timescale 1ns / 1ps
module tcce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic [1:0]            s_tuser,
    output logic                  s_tready,
    input  tcce_pkg::tcce_status_t st,
    output tcce_pkg::tcce_cmd_t   cmd
);

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_PUT0     = 5'd2;
    localparam logic [4:0] S_HIDE_EV  = 5'd3;
    localparam logic [4:0] S_PUT      = 5'd4;
    localparam logic [4:0] S_CHK      = 5'd5;
    localparam logic [4:0] S_SC_RD    = 5'd6;
    localparam logic [4:0] S_SC_WR    = 5'd7;
    localparam logic [4:0] S_BLANK    = 5'd8;
    localparam logic [4:0] S_SC_END   = 5'd9;
    localparam logic [4:0] S_REDRAW   = 5'd10;
    localparam logic [4:0] S_SHOW_MID = 5'd11;
    localparam logic [4:0] S_SHOW     = 5'd12;
    localparam logic [4:0] S_TICK     = 5'd13;
    localparam logic [4:0] S_THIDE    = 5'd14;
    localparam logic [4:0] S_TSHOW    = 5'd15;
    localparam logic [4:0] S_CRD      = 5'd16;
    localparam logic [4:0] S_CEV      = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = tcce_pkg::CMD_NONE;
        cmd.last   = 1'b0;
        cmd.latch  = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.op = tcce_pkg::CMD_CLEAR;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    case (s_tuser)
                        tcce_pkg::OP_PUT:  state_next = S_PUT0;
                        tcce_pkg::OP_TICK: state_next = S_TICK;
                        tcce_pkg::OP_READ: state_next = S_CRD;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_PUT0: begin
                if (st.geom_zero) begin
                    state_next = S_IDLE;
                end else if (st.hide_need) begin
                    cmd.op     = tcce_pkg::CMD_HIDE_RD;
                    state_next = S_HIDE_EV;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_HIDE_EV: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_HIDE_EV;
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_PUT;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (st.need_scroll) begin
                    cmd.op     = tcce_pkg::CMD_SC_INIT;
                    state_next = S_SC_RD;
                end else begin
                    state_next = S_SHOW;
                end
            end
            S_SC_RD: begin
                if (st.copy_done) begin
                    state_next = S_BLANK;
                end else begin
                    cmd.op     = tcce_pkg::CMD_SC_RD;
                    state_next = S_SC_WR;
                end
            end
            S_SC_WR: begin
                cmd.op     = tcce_pkg::CMD_SC_WR;
                state_next = S_SC_RD;
            end
            S_BLANK: begin
                cmd.op = tcce_pkg::CMD_BLANK;
                if (st.sx_last) state_next = S_SC_END;
            end
            S_SC_END: begin
                state_next = st.visible ? S_REDRAW : S_SHOW;
            end
            S_REDRAW: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_REDRAW;
                    state_next = st.blink_on ? S_SHOW_MID : S_SHOW;
                end
            end
            S_SHOW_MID: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_SHOW;
                    state_next = S_SHOW;
                end
            end
            S_SHOW: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_FINISH;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                cmd.op = tcce_pkg::CMD_TICK;
                if (!st.tick_fire)      state_next = S_IDLE;
                else if (!st.blink_on)  state_next = S_TSHOW;
                else if (st.hide_need)  state_next = S_THIDE;
                else                    state_next = S_IDLE;
            end
            S_THIDE: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_HIDE_EV;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TSHOW: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_SHOW;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CRD: begin
                cmd.op     = tcce_pkg::CMD_CELL_RD;
                state_next = S_CEV;
            end
            S_CEV: begin
                if (st.out_free) begin
                    cmd.op     = tcce_pkg::CMD_CELL_EV;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLR;
        else          state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/tcce_dp.sv =====
// tcce_dp: cell store, cursor and blink state, result register
// depends on tcce_pkg; commanded by tcce_ctrl
`timescale 1ns / 1ps
module tcce_dp #(
    parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = tcce_pkg::MAX_LINES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcce_pkg::tcce_cmd_t    cmd,
    input  tcce_pkg::tcce_cfg_t    cfg,
    input  logic [23:0]            s_tdata,
    output tcce_pkg::tcce_status_t st,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_LINES);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;

    logic [AW-1:0] clr_cnt_reg;
    logic [7:0]    in_char_reg;
    logic [6:0]    in_col_reg;
    logic [5:0]    in_row_reg;

    logic [CW-1:0] cx_reg, cx_next;
    logic [RW:0]   cy_reg, cy_next;
    logic          drawn_reg, drawn_next;
    logic [CW-1:0] dcol_reg, dcol_next;
    logic [RW-1:0] drow_reg, drow_next;
    logic          blink_reg, blink_next;
    logic [15:0]   timer_reg, timer_next;
    logic [CW-1:0] sx_reg, sx_next;
    logic [RW:0]   sy_reg, sy_next;

    logic          ov_reg, ov_next;
    logic [1:0]    ok_reg, ok_next;
    logic [6:0]    oc_reg, oc_next;
    logic [5:0]    orow_reg, orow_next;
    logic [7:0]    och_reg, och_next;
    logic          ol_reg, ol_next;

    logic [CW:0]   nc;
    logic [RW:0]   nr;
    logic [CW:0]   px;
    logic [RW:0]   py;
    logic          p_wr;
    logic [CW-1:0] p_wx;
    logic [RW-1:0] p_wy;
    logic [7:0]    p_wch;
    logic [15:0]   tnew;
    logic          in_range;
    logic          out_free;
    logic          emit;
    logic [1:0]    e_kind;
    logic [6:0]    e_col;
    logic [5:0]    e_row;
    logic [7:0]    e_ch;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
        return AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
    endfunction

    assign nc = ({1'b0, cfg.columns} > 9'(MAX_COLUMNS)) ? (CW+1)'(MAX_COLUMNS)
                                                       : (CW+1)'(cfg.columns);
    assign nr = ({2'b0, cfg.rows} > 9'(MAX_LINES)) ? (RW+1)'(MAX_LINES) : (RW+1)'(cfg.rows);

    assign tnew     = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
    assign in_range = ({2'b0, in_col_reg} < 9'(MAX_COLUMNS))
                   && ({3'b0, in_row_reg} < 9'(MAX_LINES));
    assign out_free = !ov_reg || m_tready;

    // effect of the held character on the cursor
    always_comb begin
        px    = (CW+1)'(cx_reg);
        py    = cy_reg;
        p_wr  = 1'b0;
        p_wx  = cx_reg;
        p_wy  = RW'(cy_reg);
        p_wch = in_char_reg;
        case (in_char_reg)
            tcce_pkg::CH_LF: begin
                px = '0;
                py = cy_reg + 1'b1;
            end
            tcce_pkg::CH_CR: px = '0;
            tcce_pkg::CH_BS: begin
                if (cx_reg != '0) begin
                    px = (CW+1)'(cx_reg) - 1'b1;
                end else if (cy_reg != '0) begin
                    px = nc - 1'b1;
                    py = cy_reg - 1'b1;
                end
                p_wr  = 1'b1;
                p_wx  = CW'(px);
                p_wy  = RW'(py);
                p_wch = tcce_pkg::CH_SPACE;
            end
            tcce_pkg::CH_TAB: begin
                px = ((CW+1)'(cx_reg) + (CW+1)'(tcce_pkg::TAB_STEP))
                   & ~(CW+1)'(tcce_pkg::TAB_STEP - 1);
            end
            default: begin
                p_wr = 1'b1;
                px   = (CW+1)'(cx_reg) + 1'b1;
            end
        endcase
        if (px >= nc) begin
            px = '0;
            py = py + 1'b1;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = cell_addr(sx_reg, RW'(sy_reg - 1'b1));
        wdata = rdata_reg;
        re    = 1'b0;
        raddr = cell_addr(dcol_reg, drow_reg);
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        drawn_next = drawn_reg;
        dcol_next  = dcol_reg;
        drow_next  = drow_reg;
        blink_next = blink_reg;
        timer_next = timer_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        emit   = 1'b0;
        e_kind = tcce_pkg::KIND_DRAW;
        e_col  = 7'(dcol_reg);
        e_row  = 6'(drow_reg);
        e_ch   = rdata_reg;
        case (cmd.op)
            tcce_pkg::CMD_CLEAR: begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = tcce_pkg::CH_SPACE;
            end
            tcce_pkg::CMD_HIDE_RD: re = 1'b1;
            tcce_pkg::CMD_HIDE_EV: begin
                emit       = 1'b1;
                drawn_next = 1'b0;
            end
            tcce_pkg::CMD_PUT: begin
                we      = p_wr;
                waddr   = cell_addr(p_wx, p_wy);
                wdata   = p_wch;
                emit    = p_wr && cfg.visible;
                e_col   = 7'(p_wx);
                e_row   = 6'(p_wy);
                e_ch    = p_wch;
                cx_next = CW'(px);
                cy_next = py;
            end
            tcce_pkg::CMD_SC_INIT: begin
                sx_next = '0;
                sy_next = (RW+1)'(1);
                cy_next = nr - 1'b1;
            end
            tcce_pkg::CMD_SC_RD: begin
                re    = 1'b1;
                raddr = cell_addr(sx_reg, RW'(sy_reg));
            end
            tcce_pkg::CMD_SC_WR: begin
                we = 1'b1;
                if ((CW+1)'(sx_reg) == nc - 1'b1) begin
                    sx_next = '0;
                    sy_next = sy_reg + 1'b1;
                end else begin
                    sx_next = sx_reg + 1'b1;
                end
            end
            tcce_pkg::CMD_BLANK: begin
                we      = 1'b1;
                waddr   = cell_addr(sx_reg, RW'(nr - 1'b1));
                wdata   = tcce_pkg::CH_SPACE;
                sx_next = sx_reg + 1'b1;
            end
            tcce_pkg::CMD_REDRAW: begin
                emit       = 1'b1;
                e_kind     = tcce_pkg::KIND_REDRAW;
                e_col      = '0;
                e_row      = '0;
                e_ch       = '0;
                drawn_next = 1'b0;
            end
            tcce_pkg::CMD_SHOW, tcce_pkg::CMD_FINISH: begin
                if (cfg.visible) begin
                    emit       = 1'b1;
                    drawn_next = 1'b1;
                    dcol_next  = cx_reg;
                    drow_next  = RW'(cy_reg);
                end
                e_kind = tcce_pkg::KIND_CURSOR;
                e_col  = 7'(cx_reg);
                e_row  = 6'(cy_reg);
                e_ch   = '0;
                if (cmd.op == tcce_pkg::CMD_FINISH) begin
                    blink_next = 1'b1;
                    timer_next = '0;
                end
            end
            tcce_pkg::CMD_TICK: begin
                re = 1'b1;
                if (!cfg.visible) begin
                    blink_next = 1'b0;
                    timer_next = tnew;
                end else if (tnew >= cfg.blink_period) begin
                    blink_next = !blink_reg;
                    timer_next = '0;
                end else begin
                    timer_next = tnew;
                end
            end
            tcce_pkg::CMD_CELL_RD: begin
                re    = in_range;
                raddr = cell_addr(CW'(in_col_reg), RW'(in_row_reg));
            end
            tcce_pkg::CMD_CELL_EV: begin
                emit   = 1'b1;
                e_kind = tcce_pkg::KIND_READ;
                e_col  = in_col_reg;
                e_row  = in_row_reg;
                e_ch   = in_range ? rdata_reg : tcce_pkg::CH_SPACE;
            end
            default: ;
        endcase
        // the user must make geometry and visibility writes only while idle; the block itself does not enforce this
        if (cfg.geom_wr) begin
            if ((CW+1)'(cx_reg) >= nc) cx_next = (nc != '0) ? CW'(nc - 1'b1) : '0;
            if (cy_reg >= nr)          cy_next = (nr != '0) ? nr - 1'b1 : '0;
            drawn_next = 1'b0;
        end
        if (cfg.vis_wr) begin
            blink_next = 1'b1;
            timer_next = '0;
        end
    end

    always_comb begin
        ov_next   = ov_reg;
        ok_next   = ok_reg;
        oc_next   = oc_reg;
        orow_next = orow_reg;
        och_next  = och_reg;
        ol_next   = ol_reg;
        if (emit) begin
            ov_next   = 1'b1;
            ok_next   = e_kind;
            oc_next   = e_col;
            orow_next = e_row;
            och_next  = e_ch;
            ol_next   = cmd.last;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            in_char_reg <= s_tdata[7:0];
            in_col_reg  <= s_tdata[14:8];
            in_row_reg  <= s_tdata[20:15];
        end
        ok_reg   <= ok_next;
        oc_reg   <= oc_next;
        orow_reg <= orow_next;
        och_reg  <= och_next;
        ol_reg   <= ol_next;
        dcol_reg <= dcol_next;
        drow_reg <= drow_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            drawn_reg   <= 1'b0;
            blink_reg   <= 1'b0;
            timer_reg   <= '0;
            ov_reg      <= 1'b0;
        end else begin
            if (cmd.op == tcce_pkg::CMD_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            drawn_reg <= drawn_next;
            blink_reg <= blink_next;
            timer_reg <= timer_next;
            ov_reg    <= ov_next;
        end
    end

    assign st.out_free    = out_free;
    assign st.clr_last    = (clr_cnt_reg == AW'(DEPTH - 1));
    assign st.geom_zero   = (nc == '0) || (nr == '0);
    assign st.hide_need   = cfg.visible && drawn_reg;
    assign st.need_scroll = (cy_reg >= nr);
    assign st.copy_done   = (sy_reg >= nr);
    assign st.sx_last     = ((CW+1)'(sx_reg) == nc - 1'b1);
    assign st.visible     = cfg.visible;
    assign st.blink_on    = blink_reg;
    assign st.tick_fire   = cfg.visible && (tnew >= cfg.blink_period);

    assign m_tvalid = ov_reg;
    assign m_tuser  = ok_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = {3'b000, och_reg, orow_reg, oc_reg};

endmodule
